[rtl/v3a_pkg.sv]
// Package for the three-component vector ALU.
// Holds the opcode enum, the word structs and the Q16.16 saturation helper.
// No dependencies.
package v3a_pkg;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_ADDS  = 3'd2,
    OP_SUBS  = 3'd3,
    OP_DOT   = 3'd4,
    OP_CROSS = 3'd5,
    OP_LEN   = 3'd6,
    OP_NORM  = 3'd7
  } op_e;

  typedef struct packed {
    op_e                operation;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic signed [31:0] scalar_in;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [31:0] r_z;
    logic signed [31:0] scalar_out;
    logic               ok;
  } out_word_t;

  // Lane products and the saturated add/sub result of one component
  typedef struct packed {
    logic signed [63:0] m0;
    logic signed [63:0] m1;
    logic signed [31:0] vsum;
  } lane_t;

  localparam int unsigned SqrtStages = 32;
  localparam int unsigned DivStages  = 17;

  localparam logic signed [31:0] QMax = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] QMin = 32'sh8000_0000;

  // Clamp a wide signed value to the Q16.16 range
  function automatic logic signed [31:0] sat_q(input logic signed [49:0] v);
    logic signed [31:0] r;
    if (v > 50'sd2147483647) begin
      r = QMax;
    end else if (v < -50'sd2147483648) begin
      r = QMin;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[rtl/v3a_lane.sv]
// One component lane: two signed 32x32 multipliers and a saturating adder.
// Depends on v3a_pkg.
module v3a_lane (
  input  logic               clk_i,
  input  v3a_pkg::op_e       op_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  input  logic signed [31:0] a_n1_i,
  input  logic signed [31:0] a_n2_i,
  input  logic signed [31:0] b_n1_i,
  input  logic signed [31:0] b_n2_i,
  input  logic signed [31:0] s_i,
  output v3a_pkg::lane_t     lane_o
);
  import v3a_pkg::*;

  logic signed [31:0] x0, y0, opnd;
  logic signed [32:0] sum;
  lane_t              lane_d, lane_q;

  // Pick multiplier operands and the add/sub operand
  always_comb begin
    case (op_i) inside
      OP_DOT:           begin x0 = a_i;    y0 = b_i;    end
      OP_LEN, OP_NORM:  begin x0 = a_i;    y0 = a_i;    end
      default:          begin x0 = a_n1_i; y0 = b_n2_i; end
    endcase
    case (op_i) inside
      OP_ADDS, OP_SUBS: opnd = s_i;
      default:          opnd = b_i;
    endcase
    if (op_i == OP_SUB || op_i == OP_SUBS) begin
      sum = 33'(a_i) - 33'(opnd);
    end else begin
      sum = 33'(a_i) + 33'(opnd);
    end
    lane_d.m0   = 64'(x0) * 64'(y0);
    lane_d.m1   = 64'(a_n2_i) * 64'(b_n1_i);
    lane_d.vsum = sat_q(50'(sum));
  end

  always_ff @(posedge clk_i) begin
    lane_q <= lane_d;
  end

  assign lane_o = lane_q;

endmodule

[rtl/v3a_sqrt.sv]
// Pipelined integer square root of a 64-bit value, one root bit per stage.
// Depends on v3a_pkg.
module v3a_sqrt (
  input  logic        clk_i,
  input  logic [63:0] n_i,
  output logic [31:0] root_o
);
  import v3a_pkg::*;

  logic [35:0] rem_q  [SqrtStages];
  logic [31:0] root_q [SqrtStages];
  logic [63:0] rad_q  [SqrtStages];

  for (genvar j = 0; j < SqrtStages; j++) begin : g_stage
    logic [35:0] rem_in, rem2, trial;
    logic [31:0] root_in;
    logic [63:0] rad_in;

    if (j == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = n_i;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
      assign rad_in  = rad_q[j-1];
    end

    // Bring down two radicand bits and try the next root bit
    assign rem2  = {rem_in[33:0], rad_in[63:62]};
    assign trial = {2'b00, root_in, 2'b01};

    always_ff @(posedge clk_i) begin
      rad_q[j] <= {rad_in[61:0], 2'b00};
      if (rem2 >= trial) begin
        rem_q[j]  <= rem2 - trial;
        root_q[j] <= {root_in[30:0], 1'b1};
      end else begin
        rem_q[j]  <= rem2;
        root_q[j] <= {root_in[30:0], 1'b0};
      end
    end
  end

  assign root_o = root_q[SqrtStages-1];

endmodule

[rtl/v3a_div.sv]
// Pipelined restoring divider: (mag << 16) / den, 17 quotient bits, one per stage.
// Depends on v3a_pkg.
module v3a_div (
  input  logic        clk_i,
  input  logic [31:0] mag_i,
  input  logic [31:0] den_i,
  output logic [16:0] quo_o
);
  import v3a_pkg::*;

  logic [47:0] rem_q [DivStages];
  logic [31:0] den_q [DivStages];
  logic [16:0] quo_q [DivStages];

  for (genvar k = 0; k < DivStages; k++) begin : g_stage
    localparam int unsigned Sh = DivStages - 1 - k;
    logic [47:0] rem_in, dsh;
    logic [31:0] den_in;
    logic [16:0] quo_in;

    if (k == 0) begin : g_first
      assign rem_in = {mag_i, 16'h0000};
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign dsh = {16'h0000, den_in} << Sh;

    // Subtract the shifted divisor where it fits
    always_ff @(posedge clk_i) begin
      den_q[k] <= den_in;
      if (rem_in >= dsh) begin
        rem_q[k] <= rem_in - dsh;
        quo_q[k] <= quo_in | (17'd1 << Sh);
      end else begin
        rem_q[k] <= rem_in;
        quo_q[k] <= quo_in;
      end
    end
  end

  assign quo_o = quo_q[DivStages-1];

endmodule

[rtl/vector3_alu.sv]
// Three-component Q16.16 vector ALU: add, sub, scalar add/sub, dot, cross,
// length and normalize on one input word, one result word out.
//
// Input channel in_valid_i/in_ready_o/in_word_i, output channel
// out_valid_o/out_ready_i/out_word_o; a word moves when valid and ready are
// both high. Three lanes (x, y, z) multiply and add side by side; a merge
// stage sums and saturates their products; a 32-stage square-root
// pipeline and three 17-stage divider pipelines finish length and
// normalize. Every opcode follows the same path, so every word takes as
// long as any other to reach the result register, longer only while
// a stalled receiver leaves earlier words waiting in the result queue.
// Throughput is one word per cycle. Results land in a FIFO_DEPTH-entry
// queue; a credit count of words in flight keeps in_ready_o high while
// fewer than FIFO_DEPTH words are accepted but not yet delivered, so a
// stalled receiver only stops intake once the queue would fill.
// FIFO_DEPTH must be at least 54 for full rate.
// Reset empties the pipeline, the queue and the output register.
module vector3_alu #(
  parameter int unsigned FIFO_DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  v3a_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output v3a_pkg::out_word_t out_word_o
);
  import v3a_pkg::*;

  localparam int unsigned PtrW   = $clog2(FIFO_DEPTH);
  localparam int unsigned CntW   = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned SbLen  = SqrtStages + DivStages + 1;

  typedef struct packed {
    op_e                      op;
    logic [2:0][31:0]         a;
    logic [2:0][31:0]         rv;
    logic signed [31:0]       so;
  } sb_t;

  logic                 in_acc, out_acc;
  logic [CntW-1:0]      credit_q, credit_d;

  // Stage 1: lane registers plus opcode and vector a
  logic                 s1_valid_q;
  op_e                  s1_op_q;
  logic [2:0][31:0]     s1_a_q;
  logic signed [31:0]   av [3];
  logic signed [31:0]   bv [3];
  lane_t                lane [3];

  // Stage 2 onward: sideband delay line and sum of squares
  logic                 sb_valid_q [SbLen];
  sb_t                  sb_q       [SbLen];
  sb_t                  sb_d;
  logic [63:0]          sumsq_q, sumsq_d;
  logic [31:0]          len_sq;
  logic [31:0]          len_q [DivStages];
  logic [16:0]          quo [3];

  out_word_t            res;
  out_word_t            mem [FIFO_DEPTH];
  logic [PtrW-1:0]      wr_q, rd_q;
  logic [CntW-1:0]      fcnt_q;
  logic                 fifo_we, fifo_re;
  out_word_t            out_q;
  logic                 out_valid_q;

  assign in_acc     = in_valid_i && in_ready_o;
  assign out_acc    = out_valid_q && out_ready_i;
  assign in_ready_o = (credit_q < CntW'(FIFO_DEPTH));

  // Track words accepted but not yet delivered
  always_comb begin
    credit_d = credit_q;
    if (in_acc && !out_acc) begin
      credit_d = credit_q + 1'b1;
    end else if (!in_acc && out_acc) begin
      credit_d = credit_q - 1'b1;
    end
  end

  assign av[0] = in_word_i.a_x;
  assign av[1] = in_word_i.a_y;
  assign av[2] = in_word_i.a_z;
  assign bv[0] = in_word_i.b_x;
  assign bv[1] = in_word_i.b_y;
  assign bv[2] = in_word_i.b_z;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    localparam int unsigned N1 = (i + 1) % 3;
    localparam int unsigned N2 = (i + 2) % 3;
    v3a_lane u_lane (
      .clk_i  (clk_i),
      .op_i   (in_word_i.operation),
      .a_i    (av[i]),
      .b_i    (bv[i]),
      .a_n1_i (av[N1]),
      .a_n2_i (av[N2]),
      .b_n1_i (bv[N1]),
      .b_n2_i (bv[N2]),
      .s_i    (in_word_i.scalar_in),
      .lane_o (lane[i])
    );
  end

  // Merge lane results: dot sum, cross differences, sum of squares
  always_comb begin
    logic signed [65:0] dsum;
    logic signed [64:0] diff;
    sb_d.op = s1_op_q;
    sb_d.a  = s1_a_q;
    sb_d.so = '0;
    dsum    = 66'(lane[0].m0) + 66'(lane[1].m0) + 66'(lane[2].m0);
    sumsq_d = 64'(lane[0].m0) + 64'(lane[1].m0) + 64'(lane[2].m0);
    for (int i = 0; i < 3; i++) begin
      diff = 65'(lane[i].m0) - 65'(lane[i].m1);
      case (s1_op_q) inside
        OP_ADD, OP_SUB, OP_ADDS, OP_SUBS: sb_d.rv[i] = lane[i].vsum;
        OP_CROSS: sb_d.rv[i] = sat_q(50'(signed'(diff[64:16])));
        default:  sb_d.rv[i] = '0;
      endcase
    end
    if (s1_op_q == OP_DOT) begin
      sb_d.so = sat_q(signed'(dsum[65:16]));
    end
  end

  always_ff @(posedge clk_i) begin
    s1_op_q <= in_word_i.operation;
    s1_a_q  <= {in_word_i.a_z, in_word_i.a_y, in_word_i.a_x};
    sumsq_q <= sumsq_d;
    sb_q[0] <= sb_d;
    for (int k = 1; k < SbLen; k++) begin
      sb_q[k] <= sb_q[k-1];
    end
    len_q[0] <= len_sq;
    for (int k = 1; k < DivStages; k++) begin
      len_q[k] <= len_q[k-1];
    end
  end

  v3a_sqrt u_sqrt (
    .clk_i  (clk_i),
    .n_i    (sumsq_q),
    .root_o (len_sq)
  );

  for (genvar i = 0; i < 3; i++) begin : g_div
    logic [31:0] ai, mag;
    assign ai  = sb_q[SqrtStages].a[i];
    assign mag = ai[31] ? (~ai + 32'd1) : ai;
    v3a_div u_div (
      .clk_i (clk_i),
      .mag_i (mag),
      .den_i (len_sq),
      .quo_o (quo[i])
    );
  end

  // Compose the result word at the end of the pipeline
  always_comb begin
    logic [31:0]        len;
    logic signed [31:0] len_sat;
    sb_t                sb;
    sb      = sb_q[SbLen-1];
    len     = len_q[DivStages-1];
    len_sat = len[31] ? QMax : signed'(len);
    res.r_x = signed'(sb.rv[0]);
    res.r_y = signed'(sb.rv[1]);
    res.r_z = signed'(sb.rv[2]);
    res.scalar_out = sb.so;
    res.ok  = 1'b1;
    case (sb.op)
      OP_LEN: res.scalar_out = len_sat;
      OP_NORM: begin
        if (len == '0) begin
          res.r_x = signed'(sb.a[0]);
          res.r_y = signed'(sb.a[1]);
          res.r_z = signed'(sb.a[2]);
          res.scalar_out = '0;
          res.ok  = 1'b0;
        end else begin
          res.r_x = sb.a[0][31] ? -signed'(32'(quo[0])) : signed'(32'(quo[0]));
          res.r_y = sb.a[1][31] ? -signed'(32'(quo[1])) : signed'(32'(quo[1]));
          res.r_z = sb.a[2][31] ? -signed'(32'(quo[2])) : signed'(32'(quo[2]));
          res.scalar_out = len_sat;
        end
      end
      default: ;
    endcase
  end

  assign fifo_we = sb_valid_q[SbLen-1];
  assign fifo_re = (fcnt_q != '0) && (!out_valid_q || out_ready_i);

  // Queue write and registered read
  always_ff @(posedge clk_i) begin
    if (fifo_we) begin
      mem[wr_q] <= res;
    end
    if (fifo_re) begin
      out_q <= mem[rd_q];
    end
  end

  // Control: valid line, pointers, counts, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credit_q    <= '0;
      s1_valid_q  <= 1'b0;
      for (int k = 0; k < SbLen; k++) begin
        sb_valid_q[k] <= 1'b0;
      end
      wr_q        <= '0;
      rd_q        <= '0;
      fcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      credit_q      <= credit_d;
      s1_valid_q    <= in_acc;
      sb_valid_q[0] <= s1_valid_q;
      for (int k = 1; k < SbLen; k++) begin
        sb_valid_q[k] <= sb_valid_q[k-1];
      end
      if (fifo_we) begin
        wr_q <= (wr_q == PtrW'(FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (fifo_re) begin
        rd_q <= (rd_q == PtrW'(FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (fifo_we && !fifo_re) begin
        fcnt_q <= fcnt_q + 1'b1;
      end else if (!fifo_we && fifo_re) begin
        fcnt_q <= fcnt_q - 1'b1;
      end
      if (fifo_re) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

[tb/sv/tb.sv]
// Testbench for vector3_alu: directed and random vector operations checked
// against a Q16.16 predictor built into this file. Depends on v3a_pkg.
`timescale 1ns / 1ps

module tb;
  import v3a_pkg::*;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_word_t  in_word_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_word_t out_word_o;

  vector3_alu u_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  out_word_t   result_q[$];
  int unsigned mismatches = 0;
  int unsigned words_sent = 0;
  int unsigned words_checked = 0;
  int unsigned hold_cycles = 0;
  bit          random_gaps = 1'b1;

  // Clamp a wide value to Q16.16
  function automatic logic signed [31:0] clamp_q(input logic signed [129:0] v);
    if (v > 130'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -130'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // Integer square root, floor
  function automatic logic [63:0] root_floor(input logic [65:0] n);
    logic [65:0] rem;
    logic [65:0] res;
    logic [65:0] bitv;
    rem = n;
    res = '0;
    bitv = 66'd1 << 64;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res[63:0];
  endfunction

  // Component of a unit vector, truncated toward zero
  function automatic logic signed [31:0] unit_comp(input logic signed [31:0] c,
                                                   input logic [63:0] len);
    logic [95:0] q;
    logic [95:0] m;
    m = c < 0 ? 96'(-65'(c)) : 96'(c);
    q = (m << 16) / 96'(len);
    return clamp_q(c < 0 ? -$signed({34'd0, q}) : $signed({34'd0, q}));
  endfunction

  function automatic out_word_t vector_result(input in_word_t w);
    out_word_t r;
    logic signed [129:0] acc;
    logic [65:0] sq;
    logic [63:0] len;
    r = '0;
    r.ok = 1'b1;
    case (w.operation)
      OP_ADD: begin
        r.r_x = clamp_q(130'(w.a_x) + w.b_x);
        r.r_y = clamp_q(130'(w.a_y) + w.b_y);
        r.r_z = clamp_q(130'(w.a_z) + w.b_z);
      end
      OP_SUB: begin
        r.r_x = clamp_q(130'(w.a_x) - w.b_x);
        r.r_y = clamp_q(130'(w.a_y) - w.b_y);
        r.r_z = clamp_q(130'(w.a_z) - w.b_z);
      end
      OP_ADDS: begin
        r.r_x = clamp_q(130'(w.a_x) + w.scalar_in);
        r.r_y = clamp_q(130'(w.a_y) + w.scalar_in);
        r.r_z = clamp_q(130'(w.a_z) + w.scalar_in);
      end
      OP_SUBS: begin
        r.r_x = clamp_q(130'(w.a_x) - w.scalar_in);
        r.r_y = clamp_q(130'(w.a_y) - w.scalar_in);
        r.r_z = clamp_q(130'(w.a_z) - w.scalar_in);
      end
      OP_DOT: begin
        acc = 130'(w.a_x) * w.b_x + 130'(w.a_y) * w.b_y + 130'(w.a_z) * w.b_z;
        r.scalar_out = clamp_q(acc >>> 16);
      end
      OP_CROSS: begin
        acc = 130'(w.a_y) * w.b_z - 130'(w.a_z) * w.b_y;
        r.r_x = clamp_q(acc >>> 16);
        acc = 130'(w.a_z) * w.b_x - 130'(w.a_x) * w.b_z;
        r.r_y = clamp_q(acc >>> 16);
        acc = 130'(w.a_x) * w.b_y - 130'(w.a_y) * w.b_x;
        r.r_z = clamp_q(acc >>> 16);
      end
      default: begin
        acc = 130'(w.a_x) * w.a_x + 130'(w.a_y) * w.a_y + 130'(w.a_z) * w.a_z;
        sq = acc[65:0];
        len = root_floor(sq);
        if (w.operation == OP_NORM && len == 0) begin
          r.r_x = w.a_x;
          r.r_y = w.a_y;
          r.r_z = w.a_z;
          r.ok = 1'b0;
        end else begin
          r.scalar_out = len > 64'd2147483647 ? 32'sh7FFF_FFFF : len[31:0];
          if (w.operation == OP_NORM) begin
            r.r_x = unit_comp(w.a_x, len);
            r.r_y = unit_comp(w.a_y, len);
            r.r_z = unit_comp(w.a_z, len);
          end
        end
      end
    endcase
    return r;
  endfunction

  // Offer one word, predict its result on acceptance; valid stays high
  // after acceptance so a following word can go out back to back
  task automatic send_word(input in_word_t w);
    int gap;
    gap = random_gaps ? $urandom_range(0, 4) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    result_q.push_back(vector_result(w));
    words_sent++;
    @(negedge clk_i);
  endtask

  function automatic logic signed [31:0] edge_val();
    case ($urandom_range(0, 7))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return 32'sd0;
      3: return 32'sd65536;
      4: return -32'sd65536;
      5: return 32'sd1;
      6: return $signed($urandom_range(0, 1 << 20)) - 32'sd524288;
      default: return $signed($urandom());
    endcase
  endfunction

  function automatic in_word_t rand_word(input op_e op);
    in_word_t w;
    w.operation = op;
    w.a_x = edge_val();
    w.a_y = edge_val();
    w.a_z = edge_val();
    w.b_x = edge_val();
    w.b_y = edge_val();
    w.b_z = edge_val();
    w.scalar_in = edge_val();
    return w;
  endfunction

  // Receiver: random wait before each word, or one long hold-off when requested
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_cycles != 0) begin
        out_ready_i <= 1'b0;
        repeat (hold_cycles) @(negedge clk_i);
        hold_cycles = 0;
      end
      gap = random_gaps ? $urandom_range(0, 4) : 0;
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // Compare each delivered word against the oldest prediction
  always @(posedge clk_i) begin
    out_word_t exp_w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (result_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", out_word_o);
      end else begin
        exp_w = result_q.pop_front();
        words_checked++;
        if (exp_w !== out_word_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp x=%h y=%h z=%h s=%h ok=%b got x=%h y=%h z=%h s=%h ok=%b",
                     exp_w.r_x, exp_w.r_y, exp_w.r_z, exp_w.scalar_out, exp_w.ok,
                     out_word_o.r_x, out_word_o.r_y, out_word_o.r_z,
                     out_word_o.scalar_out, out_word_o.ok);
        end
      end
    end
  end

  task automatic test_extremes();
    in_word_t w;
    for (int k = 0; k < 8; k++) begin
      w.operation = op_e'(k);
      w.a_x = 32'sh7FFF_FFFF; w.a_y = 32'sh8000_0000; w.a_z = 32'sh7FFF_FFFF;
      w.b_x = 32'sh8000_0000; w.b_y = 32'sh7FFF_FFFF; w.b_z = 32'sh8000_0000;
      w.scalar_in = k[0] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      send_word(w);
    end
  endtask

  task automatic test_small_vectors();
    in_word_t w;
    for (int k = 0; k < 8; k++) begin
      w = '0;
      w.operation = op_e'(k);
      w.a_x = 32'sd65536; w.a_y = -32'sd131072; w.a_z = 32'sd3;
      w.b_x = -32'sd1; w.b_y = 32'sd196608; w.b_z = 32'sd65536;
      w.scalar_in = -32'sd32768;
      send_word(w);
    end
  endtask

  task automatic test_zero_length();
    in_word_t w;
    w = '0;
    w.operation = OP_NORM;
    w.b_x = 32'sd5;
    w.scalar_in = -32'sd7;
    send_word(w);
    w.operation = OP_LEN;
    send_word(w);
    w.operation = OP_NORM;
    w.a_z = 32'sd1;
    send_word(w);
  endtask

  task automatic test_random(input int count);
    for (int k = 0; k < count; k++) send_word(rand_word(op_e'($urandom_range(0, 7))));
  endtask

  // Hold the receiver off so the result queue fills and intake stalls
  task automatic test_backpressure();
    random_gaps = 1'b0;
    hold_cycles = 300;
    test_random(120);
    random_gaps = 1'b1;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_extremes();
    test_small_vectors();
    test_zero_length();
    test_random(300);
    test_backpressure();
    test_random(230);
    drain();
    $display("Covered %0d words over all eight operations, with edge values,",
             words_sent);
    $display("zero-length normalize and a long output stall; %0d checked.",
             words_checked);
    if (mismatches == 0 && result_q.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("tb NOT OK");
    $finish;
  end

endmodule
